// ===== src/tlpd_pkg.sv =====
// Shared types, codes and reset constants of the two-level deframer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tlpd_pkg;

    // default length counter width and register reset value
    localparam int unsigned LEN_BITS_DEFAULT = 16;
    localparam logic [15:0] MAX_LEN_RESET    = 16'd8192;

    // input beat kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_CLOSE  = 2'd1;
    localparam logic [1:0] KIND_REOPEN = 2'd2;

    // result kinds
    localparam logic RES_DATA  = 1'b0;
    localparam logic RES_ERROR = 1'b1;

    // error codes
    localparam logic [1:0] ERR_FRAME_LEN  = 2'd0;
    localparam logic [1:0] ERR_COMPRESSED = 2'd1;
    localparam logic [1:0] ERR_RECORD_LEN = 2'd2;

    // header bit that marks a compressed body
    localparam int unsigned COMPRESS_BIT = 0;

    // register index of max_len
    localparam logic REG_MAX_LEN = 1'b0;

    // parser phase
    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_RECLEN  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_SKIP    = 4'b1000
    } t_phase;

    // one input beat
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } t_item;

    // one result beat
    typedef struct packed {
        logic       result_kind;
        logic [7:0] out_byte;
        logic       record_first;
        logic       record_last;
        logic [1:0] fault_code;
    } t_result;

endpackage

`default_nettype wire

// ===== src/tlpd_cfg.sv =====
// Configuration register file: max_len behind an APB-style port.
// Depends on tlpd_pkg; hands the effective length limit to the parser.
`default_nettype none

module tlpd_cfg
    import tlpd_pkg::*;
#(
    parameter int unsigned LEN_BITS = LEN_BITS_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output logic      [LEN_BITS-1:0] o_limit
);

    localparam int unsigned CW = (LEN_BITS > 16) ? LEN_BITS : 16;
    localparam logic [CW-1:0] LEN_MASK_C = CW'((64'd1 << LEN_BITS) - 64'd1);

    logic [15:0]   r_max_len;
    logic [CW-1:0] max_len_c;

    // register write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_LEN)) begin
            r_max_len <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_LEN) ? {16'd0, r_max_len} : 32'd0;

    // limit in force is max_len capped at the counter range
    assign max_len_c = CW'(r_max_len);
    assign o_limit   = (max_len_c < LEN_MASK_C) ? max_len_c[LEN_BITS-1:0]
                                                : LEN_MASK_C[LEN_BITS-1:0];

endmodule

`default_nettype wire

// ===== src/tlpd_in_stage.sv =====
// Input register of the deframer: holds one accepted beat for the parser.
// Depends on tlpd_pkg for the beat type.
`default_nettype none

module tlpd_in_stage
    import tlpd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_consume,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    // register refills in the same cycle the parser takes its beat
    assign o_ready = !r_valid || i_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_consume) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== src/tlpd_core.sv =====
// Parser state and per-beat decode of frame headers, record lengths and payload.
// Depends on tlpd_pkg; fed by the input stage, drives the output register.
`default_nettype none

module tlpd_core
    import tlpd_pkg::*;
#(
    parameter int unsigned LEN_BITS = LEN_BITS_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [LEN_BITS-1:0] i_limit,
    input  wire logic                i_item_valid,
    input  wire t_item               i_item,
    input  wire logic                i_out_free,
    output logic                     o_consume,
    output logic                     o_res_valid,
    output t_result                  o_res
);

    localparam int unsigned CW = (LEN_BITS > 16) ? LEN_BITS : 16;

    logic                r_closed,     n_closed;
    t_phase              r_phase,      n_phase;
    logic [1:0]          r_hdr_cnt,    n_hdr_cnt;
    logic [23:0]         r_hdr,        n_hdr;
    logic                r_cflag,      n_cflag;
    logic [LEN_BITS-1:0] r_frame_rem,  n_frame_rem;
    logic [7:0]          r_rec_lo,     n_rec_lo;
    logic [LEN_BITS-1:0] r_rec_rem,    n_rec_rem;
    logic                r_rlc,        n_rlc;

    logic [LEN_BITS-1:0] fr_dec;
    logic [LEN_BITS-1:0] rr_dec;
    logic [30:0]         hdr_len;
    logic [30:0]         lim_hdr;
    logic [CW-1:0]       rec_len_c;
    logic [CW-1:0]       lim_c;
    logic [CW-1:0]       fr_dec_c;
    logic                res_valid;
    t_result             res;

    assign fr_dec    = r_frame_rem - LEN_BITS'(1);
    assign rr_dec    = r_rec_rem - LEN_BITS'(1);
    assign hdr_len   = {i_item.rx_byte, r_hdr[23:1]};
    assign lim_hdr   = 31'(i_limit);
    assign rec_len_c = CW'({i_item.rx_byte, r_rec_lo});
    assign lim_c     = CW'(i_limit);
    assign fr_dec_c  = CW'(fr_dec);

    // next state and result for the beat in the input register
    always_comb begin
        n_closed    = r_closed;
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_hdr       = r_hdr;
        n_cflag     = r_cflag;
        n_frame_rem = r_frame_rem;
        n_rec_lo    = r_rec_lo;
        n_rec_rem   = r_rec_rem;
        n_rlc       = r_rlc;
        res_valid   = 1'b0;
        res         = '0;

        if (i_item_valid) begin
            case (i_item.kind)
                KIND_CLOSE: begin
                    n_closed = 1'b1;
                end
                KIND_REOPEN: begin
                    n_closed    = 1'b0;
                    n_phase     = PH_HEADER;
                    n_hdr_cnt   = '0;
                    n_hdr       = '0;
                    n_cflag     = 1'b0;
                    n_frame_rem = '0;
                    n_rec_lo    = '0;
                    n_rec_rem   = '0;
                    n_rlc       = 1'b0;
                end
                KIND_BYTE: begin
                    if (!r_closed) begin
                        case (r_phase)
                            // collect the four header bytes, check on the last
                            PH_HEADER: begin
                                if (r_hdr_cnt != 2'd3) begin
                                    n_hdr_cnt = r_hdr_cnt + 2'd1;
                                    case (r_hdr_cnt)
                                        2'd0:    n_hdr[7:0]   = i_item.rx_byte;
                                        2'd1:    n_hdr[15:8]  = i_item.rx_byte;
                                        default: n_hdr[23:16] = i_item.rx_byte;
                                    endcase
                                end else begin
                                    n_cflag   = r_hdr[COMPRESS_BIT];
                                    n_hdr_cnt = '0;
                                    n_hdr     = '0;
                                    if ((hdr_len == '0) || (hdr_len > lim_hdr)) begin
                                        n_closed       = 1'b1;
                                        res_valid      = 1'b1;
                                        res.result_kind = RES_ERROR;
                                        res.fault_code = ERR_FRAME_LEN;
                                    end else begin
                                        n_frame_rem = hdr_len[LEN_BITS-1:0];
                                        n_rlc       = 1'b0;
                                        n_phase     = r_hdr[COMPRESS_BIT] ? PH_SKIP : PH_RECLEN;
                                    end
                                end
                            end
                            // two-byte record length
                            PH_RECLEN: begin
                                n_frame_rem = fr_dec;
                                if (!r_rlc) begin
                                    n_rec_lo = i_item.rx_byte;
                                    n_rlc    = 1'b1;
                                    if (fr_dec == '0) begin
                                        // lone trailing byte is dropped
                                        n_rlc   = 1'b0;
                                        n_phase = PH_HEADER;
                                    end
                                end else begin
                                    n_rlc = 1'b0;
                                    if ((rec_len_c == '0) || (rec_len_c > lim_c)) begin
                                        n_closed        = 1'b1;
                                        res_valid       = 1'b1;
                                        res.result_kind = RES_ERROR;
                                        res.fault_code  = ERR_RECORD_LEN;
                                    end else if (rec_len_c <= fr_dec_c) begin
                                        n_rec_rem = rec_len_c[LEN_BITS-1:0];
                                        n_rlc     = 1'b1;
                                        n_phase   = PH_PAYLOAD;
                                    end else begin
                                        // record overruns the frame: skip the rest
                                        n_phase = (fr_dec == '0) ? PH_HEADER : PH_SKIP;
                                    end
                                end
                            end
                            // payload bytes go out with first and last marks
                            PH_PAYLOAD: begin
                                res_valid         = 1'b1;
                                res.result_kind   = RES_DATA;
                                res.out_byte      = i_item.rx_byte;
                                res.record_first  = r_rlc;
                                res.record_last   = (r_rec_rem == LEN_BITS'(1));
                                n_rlc             = 1'b0;
                                n_rec_rem         = rr_dec;
                                n_frame_rem       = fr_dec;
                                if (rr_dec == '0) begin
                                    n_phase = (fr_dec == '0) ? PH_HEADER : PH_RECLEN;
                                end
                            end
                            // discard the rest of the frame, flag a compressed body at its end
                            PH_SKIP: begin
                                n_frame_rem = fr_dec;
                                if (fr_dec == '0) begin
                                    n_phase = PH_HEADER;
                                    n_rlc   = 1'b0;
                                    if (r_cflag) begin
                                        n_cflag         = 1'b0;
                                        n_closed        = 1'b1;
                                        res_valid       = 1'b1;
                                        res.result_kind = RES_ERROR;
                                        res.fault_code  = ERR_COMPRESSED;
                                    end
                                end
                            end
                            default: begin
                                n_phase = PH_HEADER;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // a beat with no result never waits on the output side
    assign o_consume   = i_item_valid && (!res_valid || i_out_free);
    assign o_res_valid = i_item_valid && res_valid;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed    <= 1'b0;
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= '0;
            r_hdr       <= '0;
            r_cflag     <= 1'b0;
            r_frame_rem <= '0;
            r_rec_lo    <= '0;
            r_rec_rem   <= '0;
            r_rlc       <= 1'b0;
        end else if (o_consume) begin
            r_closed    <= n_closed;
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_hdr       <= n_hdr;
            r_cflag     <= n_cflag;
            r_frame_rem <= n_frame_rem;
            r_rec_lo    <= n_rec_lo;
            r_rec_rem   <= n_rec_rem;
            r_rlc       <= n_rlc;
        end
    end

endmodule

`default_nettype wire

// ===== src/tlpd_out_stage.sv =====
// Result register of the deframer: holds one result beat until it is taken.
// Depends on tlpd_pkg for the result type.
`default_nettype none

module tlpd_out_stage
    import tlpd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    // free when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ===== src/two_level_length_prefix_deframer.sv =====
// Top level of the two-level length-prefixed deframer.
// Depends on tlpd_pkg, tlpd_cfg, tlpd_in_stage, tlpd_core and tlpd_out_stage.
//
//  channel  | direction | signals                                  | content
//  ---------+-----------+------------------------------------------+----------------------------
//  s stream | in        | i_s_tvalid o_s_tready i_s_tdata i_s_tuser | rx byte, beat kind
//  m stream | out       | o_m_tvalid i_m_tready o_m_tdata o_m_tuser | record byte or error
//           |           | o_m_tlast                                 | last byte of a record
//  apb      | in/out    | psel penable pwrite paddr pwdata prdata   | max_len at byte address 0
//
// One beat per cycle while the m side takes results; a beat is decoded from the input
// register and its result is loaded into the result register, which drives the m side.
// The rate is set by the combinational decode between input and result registers.
// Synchronous active-low reset clears the parser to header phase, session open.
// A stalled m side only holds the s side once both the result and input
// registers are full; beats that give no result drain regardless.
`default_nettype none

module two_level_length_prefix_deframer
    import tlpd_pkg::*;
#(
    parameter int unsigned LEN_BITS = LEN_BITS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  i_s_tuser,   // [1:0] kind
    // master stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata,   // [7:0] out_byte, [9:8] fault_code, [15:10] zero
    output logic      [1:0]  o_m_tuser,   // [0] result_kind, [1] record_first
    output logic             o_m_tlast,   // record_last
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [LEN_BITS-1:0] limit;
    t_item               s_item;
    t_item               core_item;
    logic                core_item_valid;
    logic                consume;
    logic                out_free;
    logic                res_valid;
    t_result             res;
    t_result             m_res;

    assign s_item.kind    = i_s_tuser;
    assign s_item.rx_byte = i_s_tdata;

    // register file
    tlpd_cfg #(
        .LEN_BITS (LEN_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_limit (limit)
    );

    // input register
    tlpd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (s_item),
        .i_consume (consume),
        .o_valid   (core_item_valid),
        .o_item    (core_item)
    );

    // parser
    tlpd_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_limit      (limit),
        .i_item_valid (core_item_valid),
        .i_item       (core_item),
        .i_out_free   (out_free),
        .o_consume    (consume),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // result register
    tlpd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid && out_free),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (m_res)
    );

    assign o_m_tdata = {6'd0, m_res.fault_code, m_res.out_byte};
    assign o_m_tuser = {m_res.record_first, m_res.result_kind};
    assign o_m_tlast = m_res.record_last;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the two-level length-prefixed deframer.
// Needs tlpd_pkg and two_level_length_prefix_deframer; a scoreboard class holds
// its own copy of the parser and compares every result beat in order.
`default_nettype none

module tb_top;
    import tlpd_pkg::*;

    localparam logic [1:0] KIND_UNUSED       = 2'd3;
    localparam int         CYCLE_LIMIT       = 500000;
    localparam int         HOLD_CYCLES       = 300;
    localparam int         DRAIN_CYCLES      = 8;
    localparam int         BEATS_PER_SETTING = 40;

    typedef logic [7:0] t_byte_q[$];

    // predictor of the deframer plus the queue of expected result beats
    class deframer_scoreboard;
        logic [15:0] max_len;
        bit          closed;
        t_phase      phase;
        logic [1:0]  hdr_cnt;
        logic [31:0] hdr_word;
        bit          compressed;
        logic [15:0] frame_left;
        logic [7:0]  rec_low;
        logic [15:0] rec_left;
        bit          len_seen;
        t_result     expected_q[$];
        int          fail_count;
        int          n_used;
        int          n_data;
        int          n_records;
        int          n_err[3];

        function new();
            max_len = MAX_LEN_RESET;
            closed  = 0;
            restart();
        endfunction

        function void restart();
            phase      = PH_HEADER;
            hdr_cnt    = '0;
            hdr_word   = '0;
            compressed = 0;
            frame_left = '0;
            rec_low    = '0;
            rec_left   = '0;
            len_seen   = 0;
        endfunction

        function void push_error(logic [1:0] code);
            t_result r;
            r = '0;
            r.result_kind = RES_ERROR;
            r.fault_code  = code;
            closed = 1;
            n_err[code]++;
            expected_q.push_back(r);
        endfunction

        // advance the parser by one accepted beat; returns 1 unless ignored
        function bit note_beat(logic [1:0] kind, logic [7:0] b);
            logic [31:0] hlen;
            logic [15:0] rlen;
            t_result     r;
            if (kind == KIND_CLOSE) begin
                closed = 1;
                n_used++;
                return 1;
            end
            if (kind == KIND_REOPEN) begin
                restart();
                closed = 0;
                n_used++;
                return 1;
            end
            if (kind != KIND_BYTE || closed) return 0;
            n_used++;
            case (phase)
                PH_HEADER: begin
                    hdr_word = hdr_word | ({24'd0, b} << (8 * hdr_cnt));
                    if (hdr_cnt != 2'd3) begin
                        hdr_cnt++;
                    end else begin
                        hlen       = hdr_word >> 1;
                        compressed = hdr_word[COMPRESS_BIT];
                        hdr_cnt    = '0;
                        hdr_word   = '0;
                        if (hlen == 0 || hlen > {16'd0, max_len}) begin
                            push_error(ERR_FRAME_LEN);
                        end else begin
                            frame_left = hlen[15:0];
                            len_seen   = 0;
                            if (compressed) phase = PH_SKIP;
                            else phase = PH_RECLEN;
                        end
                    end
                end
                PH_RECLEN: begin
                    frame_left--;
                    if (!len_seen) begin
                        rec_low  = b;
                        len_seen = 1;
                        // lone trailing byte ends the frame
                        if (frame_left == 0) begin
                            len_seen = 0;
                            phase    = PH_HEADER;
                        end
                    end else begin
                        rlen     = {b, rec_low};
                        len_seen = 0;
                        if (rlen == 0 || rlen > max_len) begin
                            push_error(ERR_RECORD_LEN);
                        end else if (rlen <= frame_left) begin
                            rec_left = rlen;
                            len_seen = 1;
                            phase    = PH_PAYLOAD;
                        end else if (frame_left == 0) begin
                            phase = PH_HEADER;
                        end else begin
                            phase = PH_SKIP;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    r = '0;
                    r.result_kind  = RES_DATA;
                    r.out_byte     = b;
                    r.record_first = len_seen;
                    r.record_last  = (rec_left == 16'd1);
                    expected_q.push_back(r);
                    n_data++;
                    if (len_seen) n_records++;
                    len_seen = 0;
                    rec_left--;
                    frame_left--;
                    if (rec_left == 0) begin
                        if (frame_left == 0) phase = PH_HEADER;
                        else phase = PH_RECLEN;
                    end
                end
                default: begin
                    // skipping the rest of a frame
                    frame_left--;
                    if (frame_left == 0) begin
                        phase    = PH_HEADER;
                        len_seen = 0;
                        if (compressed) begin
                            compressed = 0;
                            push_error(ERR_COMPRESSED);
                        end
                    end
                end
            endcase
            return 1;
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                fail_count++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result beat, expected none, actual 0x%0h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            check_field("result_kind", 8'(want.result_kind), 8'(got.result_kind));
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("record_first", 8'(want.record_first), 8'(got.record_first));
            check_field("record_last", 8'(want.record_last), 8'(got.record_last));
            check_field("fault_code", 8'(want.fault_code), 8'(got.fault_code));
        endfunction

        function void report_leftover();
            if (expected_q.size() != 0) begin
                fail_count += expected_q.size();
                $display("%0t: %0d result beats never arrived, oldest expected 0x%0h",
                         $time, expected_q.size(), expected_q[0]);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    deframer_scoreboard sb = new();
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_left    = 0;
    int cycle_count  = 0;
    int n_cfg        = 0;

    two_level_length_prefix_deframer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d result beats outstanding",
                     $time, sb.expected_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: check each accepted beat, then pick the next tready
    always @(posedge i_clk) begin
        t_result got;
        if (o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            got.result_kind  = o_m_tuser[0];
            got.record_first = o_m_tuser[1];
            got.out_byte     = o_m_tdata[7:0];
            got.fault_code   = o_m_tdata[9:8];
            got.record_last  = o_m_tlast;
            sb.check_result(got);
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(logic [1:0] kind, logic [7:0] b);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        void'(sb.note_beat(kind, b));
    endtask

    task automatic send_bytes(t_byte_q q);
        foreach (q[i]) send_beat(KIND_BYTE, q[i]);
    endtask

    // 4-byte little-endian frame header
    task automatic send_header(logic [31:0] len, logic comp);
        logic [31:0] word;
        word = {len[30:0], comp};
        for (int i = 0; i < 4; i++) send_beat(KIND_BYTE, word[8*i +: 8]);
    endtask

    // stop offering beats until every expected result is out and the block is idle
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_len(logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_LEN, 2'b00};
        pwdata  <= {16'($urandom()), v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.max_len = v;
        n_cfg++;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // bring the parser back to a clean header boundary when needed
    task automatic resync();
        if (sb.closed || sb.phase != PH_HEADER || sb.hdr_cnt != 0)
            send_beat(KIND_REOPEN, 8'($urandom_range(255)));
    endtask

    // well-formed frame of small records, sometimes with an odd ending
    task automatic send_frame(int lim);
        t_byte_q body;
        int      n_rec;
        int      room;
        int      cap;
        int      len;
        int      k;
        int      r;
        n_rec = $urandom_range(1, 4);
        for (int i = 0; i < n_rec; i++) begin
            room = lim - body.size() - 2;
            if (room < 1) break;
            cap = ($urandom_range(99) < 3) ? 300 : 12;
            len = $urandom_range(1, (room < cap) ? room : cap);
            body.push_back(len[7:0]);
            body.push_back(len[15:8]);
            repeat (len) body.push_back(8'($urandom_range(255)));
        end
        r = $urandom_range(9);
        if (r < 2 && body.size() + 1 <= lim) begin
            // lone trailing byte
            body.push_back(8'($urandom_range(255)));
        end else if (r < 4 && body.size() + 2 <= lim) begin
            // record longer than what is left of the frame
            room = lim - body.size() - 2;
            k    = $urandom_range(0, (room < 3) ? room : 3);
            len  = $urandom_range(k + 1, (lim < k + 60) ? lim : k + 60);
            body.push_back(len[7:0]);
            body.push_back(len[15:8]);
            repeat (k) body.push_back(8'($urandom_range(255)));
        end
        if (body.size() == 0) body.push_back(8'($urandom_range(255)));
        send_header(body.size(), 1'b0);
        send_bytes(body);
    endtask

    // one random stretch of stimulus, mostly well-formed frames
    task automatic random_burst();
        int          lim;
        int          r;
        int          flen;
        logic [31:0] bad_len;
        logic [15:0] rlen;
        lim = sb.max_len;
        r   = $urandom_range(99);
        if (r < 68) begin
            resync();
            send_frame(lim);
        end else if (r < 76) begin
            // compressed body, reported once consumed
            resync();
            flen = $urandom_range(1, (lim < 10) ? lim : 10);
            send_header(flen, 1'b1);
            repeat (flen) send_beat(KIND_BYTE, 8'($urandom_range(255)));
        end else if (r < 82 || (r < 88 && lim < 2)) begin
            // frame length out of range
            resync();
            case ($urandom_range(2))
                0: bad_len = '0;
                1: bad_len = lim + $urandom_range(1, 5);
                default: bad_len = $urandom_range(65536, 32'h7FFF_FFFF);
            endcase
            send_header(bad_len, 1'($urandom_range(1)));
        end else if (r < 88) begin
            // record length out of range
            resync();
            flen = $urandom_range(2, (lim < 20) ? lim : 20);
            send_header(flen, 1'b0);
            if (lim < 65535 && $urandom_range(1) == 1)
                rlen = 16'($urandom_range(lim + 1, 65535));
            else
                rlen = '0;
            send_beat(KIND_BYTE, rlen[7:0]);
            send_beat(KIND_BYTE, rlen[15:8]);
        end else if (r < 92) begin
            send_beat(KIND_CLOSE, 8'($urandom_range(255)));
        end else if (r < 95) begin
            send_beat(KIND_REOPEN, 8'($urandom_range(255)));
        end else begin
            // noise of any kind
            repeat ($urandom_range(1, 4))
                send_beat(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
    endtask

    // stimulus
    initial begin
        logic [15:0] setting;
        int          target;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= KIND_BYTE;
        i_m_tready <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: record with extreme bytes, then a lone trailing byte
        send_bytes('{8'h08, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'hFF, 8'h00});
        send_beat(KIND_UNUSED, 8'h5A);
        // record longer than the frame, rest skipped
        send_bytes('{8'h06, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h77});
        // compressed body
        send_bytes('{8'h03, 8'h00, 8'h00, 8'h00, 8'hC3});
        // byte and close while closed, then reopen
        send_beat(KIND_BYTE, 8'hAA);
        send_beat(KIND_CLOSE, 8'h00);
        send_beat(KIND_REOPEN, 8'h00);
        // zero frame length
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h00});
        send_beat(KIND_REOPEN, 8'hFF);
        // reopen in the middle of a header while open
        send_bytes('{8'h0A, 8'h00});
        send_beat(KIND_REOPEN, 8'h00);
        // zero record length
        send_bytes('{8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_beat(KIND_REOPEN, 8'h00);
        // close while open
        send_beat(KIND_CLOSE, 8'hFF);
        send_beat(KIND_REOPEN, 8'h00);
        // max_len of zero rejects every frame
        wait_drained();
        write_max_len(16'd0);
        send_bytes('{8'h02, 8'h00, 8'h00, 8'h00});
        send_beat(KIND_REOPEN, 8'h00);

        // random part: three idling patterns, three settings each
        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 84 : 0;
            rcv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 32 : 0;
            for (int sub = 0; sub < 3; sub++) begin
                wait_drained();
                case (ph * 3 + sub)
                    0: setting = 16'd200;
                    1: setting = 16'd1;
                    2: setting = 16'($urandom_range(3, 40));
                    3: setting = 16'd65535;
                    4: setting = 16'($urandom_range(1, 65535));
                    5: setting = MAX_LEN_RESET;
                    6: setting = 16'($urandom_range(3, 40));
                    7: setting = 16'd65535;
                    default: setting = 16'd1000;
                endcase
                write_max_len(setting);
                // long receiver stall while the sender keeps going
                if (ph == 2 && sub == 0) hold_left = HOLD_CYCLES;
                target = sb.n_used + BEATS_PER_SETTING;
                while (sb.n_used < target) random_burst();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.report_leftover();
        $display("covered %0d consumed beats, %0d record bytes in %0d records, %0d max_len writes",
                 sb.n_used, sb.n_data, sb.n_records, n_cfg);
        $display("session-closing errors: frame length %0d, compressed %0d, record length %0d",
                 sb.n_err[0], sb.n_err[1], sb.n_err[2]);
        if (sb.fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
